// File: hw/rtl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types, constants and modular helpers for the hash table block.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int NUM_SLOTS  = 1021;
  localparam int SLOT_W     = 10;
  localparam int KEY_WORDS  = 4;
  localparam int KEY_BITS   = KEY_WORDS * 64;
  localparam int KEY_BYTES  = KEY_WORDS * 8;
  localparam int KB_W       = 5;
  localparam int CNT_W      = 6;

  localparam logic [63:0] DJB2_INIT = 64'd5381;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic [SLOT_W:0] MODULUS = (SLOT_W + 1)'(NUM_SLOTS);

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] key_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] probe_count;
  } out_item_t;

  typedef struct packed {
    logic              occ_we;
    logic              key_we;
    logic [SLOT_W-1:0] addr;
    logic              occ_bit;
  } store_wr_t;

  // fold one byte, msb first, into a residue mod table size
  function automatic logic [SLOT_W-1:0] mod_step8(input logic [SLOT_W-1:0] r,
                                                  input logic [7:0] b);
    logic [SLOT_W:0]   x;
    logic [SLOT_W-1:0] acc;
    acc = r;
    for (int i = 7; i >= 0; i--) begin
      x = {acc, b[i]};
      if (x >= MODULUS) x = x - MODULUS;
      acc = x[SLOT_W-1:0];
    end
    return acc;
  endfunction

  // sum of two residues mod table size
  function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                                input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MODULUS) s = s - MODULUS;
    return s[SLOT_W-1:0];
  endfunction

endpackage

// File: hw/rtl/oaht_store.sv
// ----------------------------------------------------------------------------
// oaht_store
// Occupancy map and key store, one slot per entry, registered reads.
// ----------------------------------------------------------------------------
module oaht_store import oaht_pkg::*; (
  input  logic                clk,
  input  store_wr_t           wr,
  input  logic [KEY_BITS-1:0] key_wdata,
  input  logic [SLOT_W-1:0]   rd_addr,
  output logic                occ_rdata,
  output logic [KEY_BITS-1:0] key_rdata
);

  logic                occ_mem [NUM_SLOTS];
  logic [KEY_BITS-1:0] key_mem [NUM_SLOTS];

  // occupancy bits
  always_ff @(posedge clk) begin
    if (wr.occ_we) occ_mem[wr.addr] <= wr.occ_bit;
    occ_rdata <= occ_mem[rd_addr];
  end

  // stored keys, all words of a slot side by side
  always_ff @(posedge clk) begin
    if (wr.key_we) key_mem[wr.addr] <= key_wdata;
    key_rdata <= key_mem[rd_addr];
  end

endmodule

// File: hw/rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Byte-fed string key hash table with linear, quadratic or double probing.
// ----------------------------------------------------------------------------
// A byte that does not end a key only updates the hashes and key buffer; a too-long
// key has its result registered in the cycle after its last byte. Otherwise the
// hashes are reduced (S_RED), each probed slot is read (S_RD) and compared (S_CHK),
// and the result is loaded in S_DONE once the output is free; input stalls meanwhile.
// A clear request sweeps the occupancy memory one slot a cycle, over all 1021 slots.
// Reset (rst, synchronous) runs the same sweep before the first request is taken.
module open_addressing_hash_table import oaht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RED   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state;
  logic [1:0]          probe_mode;
  logic [KEY_BITS-1:0] key_buffer;
  logic [CNT_W-1:0]    byte_count;
  logic [63:0]         djb2_acc;
  logic [31:0]         sdbm_acc;
  logic [SLOT_W-1:0]   clr_addr;
  logic [2:0]          red_cnt;
  logic [SLOT_W-1:0]   home;
  logic [SLOT_W-1:0]   step;
  logic [SLOT_W-1:0]   pos;
  logic [SLOT_W-1:0]   off;
  logic [SLOT_W-1:0]   dq;
  logic [SLOT_W-1:0]   t;
  logic                is_insert;
  out_item_t           res;

  logic                in_acc, need_res, out_free, too_long, res_load;
  logic [63:0]         djb2_next;
  logic [31:0]         sdbm_next;
  logic [KEY_BITS-1:0] key_buffer_next;
  logic [CNT_W-1:0]    byte_count_next;
  logic [SLOT_W-1:0]   inc, off_next, pos_next, dq_next, t_next;
  logic                hit;
  store_wr_t           wr;
  logic                occ_rdata;
  logic [KEY_BITS-1:0] key_rdata;

  assign cfg_ready = 1'b1;

  // input handshake
  assign need_res = (in_data.command inside {CMD_INSERT, CMD_LOOKUP}) && in_data.last_byte;
  assign in_stall = (state != S_IDLE) || (need_res && out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign res_load = (state == S_IDLE && in_acc && need_res && too_long) ||
                    (state == S_DONE && out_free);

  // hash and key packing for the incoming byte
  always_comb begin
    djb2_next = (djb2_acc << 5) + djb2_acc + {56'b0, in_data.key_byte};
    sdbm_next = {24'b0, in_data.key_byte} + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
    key_buffer_next = key_buffer;
    if (byte_count < CNT_W'(KEY_BYTES))
      key_buffer_next[{byte_count[KB_W-1:0], 3'b000} +: 8] =
        key_buffer[{byte_count[KB_W-1:0], 3'b000} +: 8] | in_data.key_byte;
    byte_count_next = (byte_count <= CNT_W'(KEY_BYTES)) ? byte_count + 1'b1 : byte_count;
    too_long = byte_count_next > CNT_W'(KEY_BYTES);
  end

  // next probe position
  always_comb begin
    if (probe_mode == MODE_QUAD)        inc = dq;
    else if (probe_mode == MODE_DOUBLE) inc = step;
    else                                inc = SLOT_W'(1);
    off_next = add_mod(off, inc);
    pos_next = add_mod(home, off_next);
    dq_next  = add_mod(dq, SLOT_W'(2));
    t_next   = t + 1'b1;
    hit = is_insert ? !occ_rdata : (occ_rdata && key_rdata == key_buffer);
  end

  // memory write control
  always_comb begin
    wr = '0;
    if (state == S_CLEAR) begin
      wr.occ_we = 1'b1;
      wr.addr   = clr_addr;
    end else if (state == S_CHK && hit && is_insert) begin
      wr.occ_we  = 1'b1;
      wr.key_we  = 1'b1;
      wr.addr    = pos;
      wr.occ_bit = 1'b1;
    end
  end

  oaht_store u_store (
    .clk       (clk),
    .wr        (wr),
    .key_wdata (key_buffer),
    .rd_addr   (pos),
    .occ_rdata (occ_rdata),
    .key_rdata (key_rdata)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      probe_mode <= '0;
      key_buffer <= '0;
      byte_count <= '0;
      djb2_acc   <= DJB2_INIT;
      sdbm_acc   <= '0;
    end else begin
      if (cfg_valid) probe_mode <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_W'(NUM_SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.command == CMD_CLEAR) begin
              key_buffer <= '0;
              byte_count <= '0;
              djb2_acc   <= DJB2_INIT;
              sdbm_acc   <= '0;
              clr_addr   <= '0;
              state      <= S_CLEAR;
            end else if (in_data.command inside {CMD_INSERT, CMD_LOOKUP}) begin
              if (in_data.last_byte && too_long) begin
                out_data.status      <= ST_TOO_LONG;
                out_data.slot_index  <= '0;
                out_data.probe_count <= '0;
                key_buffer <= '0;
                byte_count <= '0;
                djb2_acc   <= DJB2_INIT;
                sdbm_acc   <= '0;
              end else begin
                key_buffer <= key_buffer_next;
                byte_count <= byte_count_next;
                djb2_acc   <= djb2_next;
                sdbm_acc   <= sdbm_next;
                if (in_data.last_byte) begin
                  is_insert <= (in_data.command == CMD_INSERT);
                  red_cnt   <= '0;
                  home      <= '0;
                  step      <= '0;
                  state     <= S_RED;
                end
              end
            end
          end
        end
        S_RED: begin
          // one byte of the djb2 hash per cycle, msb first; sdbm only for its four bytes
          home     <= mod_step8(home, djb2_acc[63:56]);
          djb2_acc <= djb2_acc << 8;
          if (red_cnt < 3'd4) begin
            step     <= mod_step8(step, sdbm_acc[31:24]);
            sdbm_acc <= sdbm_acc << 8;
          end
          red_cnt <= red_cnt + 1'b1;
          if (red_cnt == 3'd7) begin
            pos   <= mod_step8(home, djb2_acc[63:56]);
            off   <= '0;
            dq    <= SLOT_W'(1);
            t     <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (hit) begin
            res.status      <= is_insert ? ST_INSERTED : ST_FOUND;
            res.slot_index  <= pos;
            res.probe_count <= t;
            state           <= S_DONE;
          end else if (pos_next == home) begin
            res.status      <= is_insert ? ST_FULL : ST_NOT_FOUND;
            res.slot_index  <= '0;
            res.probe_count <= t_next;
            state           <= S_DONE;
          end else begin
            pos   <= pos_next;
            off   <= off_next;
            dq    <= dq_next;
            t     <= t_next;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data   <= res;
            key_buffer <= '0;
            byte_count <= '0;
            djb2_acc   <= DJB2_INIT;
            sdbm_acc   <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // an insert only claims a slot that read back free
  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    (wr.key_we) |-> (!occ_rdata && state == S_CHK))
    else $error("insert into occupied slot");

  // the walk never runs past one lap of the table
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (t < SLOT_W'(NUM_SLOTS) && pos < SLOT_W'(NUM_SLOTS)))
    else $error("probe walk out of range");

  // a new result is never loaded during a clearing sweep
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !$rose(out_valid))
    else $error("result during clear");
`endif

endmodule
